// File: src/i2cra_pkg.sv
package i2cra_pkg;

    localparam int unsigned TicksW = 16;
    localparam logic [TicksW-1:0] TicksReset = 16'd50;

    // request kinds
    localparam logic KindWrite = 1'b0;
    localparam logic KindRead  = 1'b1;

    // address byte direction bit
    localparam logic RwWrite = 1'b0;
    localparam logic RwRead  = 1'b1;

    typedef struct packed {
        logic       req_valid;
        logic       req_type;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic [7:0] byte_count;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_oe;
        logic       busy_res;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       rd_last;
        logic       nack_seen;
    } result_t;

endpackage

// File: src/i2cra_seq.sv
module i2cra_seq import i2cra_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  item_t             item,
    input  logic [TicksW-1:0] half_bit_ticks,
    output result_t           result
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_SB_A, PH_SB_B, PH_WA_A, PH_WA_B, PH_WA_C,
        PH_GAP, PH_RB_A, PH_RB_B, PH_RB_C, PH_RB_D, PH_RB_E, PH_AK_A, PH_AK_B,
        PH_AK_C, PH_SP_A, PH_SP_B, PH_SP_C, PH_FINAL
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [TicksW-1:0] delay_count;
        logic [3:0]        bit_index;
        logic [7:0]        shift_byte;
        logic [7:0]        bytes_left;
        logic [6:0]        dev;
        logic [7:0]        rega;
        logic [7:0]        wbyte;
        logic              kind;
        logic              nack;
        logic              scl;
        logic              sda;
        logic [1:0]        stage;
        logic              drive;
    } seq_state_t;

    // bus idle with both lines high and SDA driven
    localparam seq_state_t StReset = '{phase: PH_IDLE, scl: 1'b1, sda: 1'b1, drive: 1'b1,
                                       default: '0};

    seq_state_t st_reg, st_next;
    result_t    result_reg, result_next;

    logic [TicksW-1:0] ticks_eff;
    assign ticks_eff = (half_bit_ticks == '0) ? TicksW'(1) : half_bit_ticks;

    always_comb begin
        logic       do_enter;
        phase_t     enter_ph;
        logic       do_load;
        logic [7:0] load_byte;
        logic       do_shift;
        logic [3:0] idx_inc;
        logic [7:0] bl_dec;

        st_next   = st_reg;
        do_enter  = 1'b0;
        enter_ph  = PH_IDLE;
        do_load   = 1'b0;
        load_byte = '0;
        do_shift  = 1'b0;
        idx_inc   = st_reg.bit_index + 4'd1;
        bl_dec    = (st_reg.bytes_left != 8'd0) ? st_reg.bytes_left - 8'd1 : 8'd0;

        result_next          = '0;

        if (st_reg.phase == PH_IDLE) begin
            if (item.req_valid) begin
                st_next.kind       = item.req_type;
                st_next.dev        = item.dev_addr;
                st_next.rega       = item.reg_addr;
                st_next.wbyte      = item.wr_data;
                st_next.bytes_left = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
                st_next.nack       = 1'b0;
                st_next.stage      = 2'd0;
                st_next.drive      = 1'b1;
                st_next.sda        = 1'b1;
                st_next.scl        = 1'b1;
                do_enter           = 1'b1;
                enter_ph           = PH_ST_A;
            end
        end else if (st_reg.delay_count > TicksW'(1)) begin
            st_next.delay_count = st_reg.delay_count - TicksW'(1);
        end else begin
            unique case (st_reg.phase)
                PH_ST_A: begin
                    st_next.sda = 1'b0;
                    do_enter = 1'b1; enter_ph = PH_ST_B;
                end
                PH_ST_B: begin
                    st_next.scl = 1'b0;
                    do_load   = 1'b1;
                    load_byte = {st_reg.dev, (st_reg.stage == 2'd2) ? RwRead : RwWrite};
                end
                PH_SB_A: begin
                    st_next.scl = 1'b1;
                    do_enter = 1'b1; enter_ph = PH_SB_B;
                end
                PH_SB_B: begin
                    st_next.scl       = 1'b0;
                    st_next.bit_index = idx_inc;
                    if (idx_inc < 4'd8) begin
                        do_shift = 1'b1;
                    end else begin
                        st_next.drive = 1'b0;
                        do_enter = 1'b1; enter_ph = PH_WA_A;
                    end
                end
                PH_WA_A: begin
                    st_next.scl = 1'b1;
                    do_enter = 1'b1; enter_ph = PH_WA_B;
                end
                PH_WA_B: begin
                    if (item.sda_in) begin
                        st_next.nack = 1'b1;
                    end
                    st_next.drive = 1'b1;
                    st_next.scl   = 1'b0;
                    do_enter = 1'b1; enter_ph = PH_WA_C;
                end
                PH_WA_C: begin
                    if (st_reg.kind == KindWrite) begin
                        do_enter = 1'b1; enter_ph = PH_GAP;
                    end else if (st_reg.stage == 2'd0) begin
                        st_next.stage = 2'd1;
                        do_load = 1'b1; load_byte = st_reg.rega;
                    end else if (st_reg.stage == 2'd1) begin
                        // repeated start before the read address
                        st_next.stage = 2'd2;
                        st_next.sda   = 1'b1;
                        st_next.scl   = 1'b1;
                        do_enter = 1'b1; enter_ph = PH_ST_A;
                    end else begin
                        st_next.scl = 1'b0;
                        do_enter = 1'b1; enter_ph = PH_RB_A;
                    end
                end
                PH_GAP: begin
                    if (st_reg.stage == 2'd0) begin
                        st_next.stage = 2'd1;
                        do_load = 1'b1; load_byte = st_reg.rega;
                    end else if (st_reg.stage == 2'd1) begin
                        st_next.stage = 2'd2;
                        do_load = 1'b1; load_byte = st_reg.wbyte;
                    end else begin
                        st_next.sda = 1'b0;
                        st_next.scl = 1'b0;
                        do_enter = 1'b1; enter_ph = PH_SP_A;
                    end
                end
                PH_RB_A: begin
                    st_next.sda        = 1'b1;
                    st_next.drive      = 1'b0;
                    st_next.bit_index  = 4'd0;
                    st_next.shift_byte = 8'd0;
                    do_enter = 1'b1; enter_ph = PH_RB_B;
                end
                PH_RB_B: begin
                    st_next.scl = 1'b0;
                    do_enter = 1'b1; enter_ph = PH_RB_C;
                end
                PH_RB_C: begin
                    st_next.scl = 1'b1;
                    do_enter = 1'b1; enter_ph = PH_RB_D;
                end
                PH_RB_D: begin
                    st_next.shift_byte = {st_reg.shift_byte[6:0], item.sda_in};
                    st_next.bit_index  = idx_inc;
                    if (idx_inc < 4'd8) begin
                        do_enter = 1'b1; enter_ph = PH_RB_B;
                    end else begin
                        result_next.rd_valid = 1'b1;
                        result_next.rd_data  = {st_reg.shift_byte[6:0], item.sda_in};
                        result_next.rd_last  = (st_reg.bytes_left <= 8'd1);
                        st_next.drive = 1'b1;
                        st_next.scl   = 1'b0;
                        do_enter = 1'b1; enter_ph = PH_RB_E;
                    end
                end
                PH_RB_E: begin
                    st_next.scl = 1'b0;
                    do_enter = 1'b1; enter_ph = PH_AK_A;
                end
                PH_AK_A: begin
                    // ACK all but the last byte
                    st_next.sda = (st_reg.bytes_left > 8'd1) ? 1'b0 : 1'b1;
                    st_next.scl = 1'b1;
                    do_enter = 1'b1; enter_ph = PH_AK_B;
                end
                PH_AK_B: begin
                    st_next.scl = 1'b0;
                    do_enter = 1'b1; enter_ph = PH_AK_C;
                end
                PH_AK_C: begin
                    st_next.bytes_left = bl_dec;
                    if (bl_dec != 8'd0) begin
                        st_next.scl = 1'b0;
                        do_enter = 1'b1; enter_ph = PH_RB_A;
                    end else begin
                        st_next.sda = 1'b0;
                        st_next.scl = 1'b0;
                        do_enter = 1'b1; enter_ph = PH_SP_A;
                    end
                end
                PH_SP_A: begin
                    st_next.scl = 1'b1;
                    do_enter = 1'b1; enter_ph = PH_SP_B;
                end
                PH_SP_B: begin
                    st_next.sda = 1'b1;
                    do_enter = 1'b1; enter_ph = PH_SP_C;
                end
                PH_SP_C: begin
                    if (st_reg.kind == KindWrite) begin
                        do_enter = 1'b1; enter_ph = PH_FINAL;
                    end else begin
                        st_next.phase       = PH_IDLE;
                        st_next.delay_count = '0;
                    end
                end
                default: begin
                    st_next.phase       = PH_IDLE;
                    st_next.delay_count = '0;
                end
            endcase
        end

        if (do_load) begin
            st_next.shift_byte = load_byte;
            st_next.bit_index  = 4'd0;
        end
        if (do_load || do_shift) begin
            st_next.sda        = st_next.shift_byte[7];
            st_next.shift_byte = {st_next.shift_byte[6:0], 1'b0};
            do_enter = 1'b1;
            enter_ph = PH_SB_A;
        end
        if (do_enter) begin
            st_next.phase       = enter_ph;
            st_next.delay_count = ticks_eff;
        end

        result_next.scl       = st_next.scl;
        result_next.sda_oe    = st_next.drive;
        result_next.sda_out   = st_next.drive & st_next.sda;
        result_next.busy_res  = (st_next.phase != PH_IDLE);
        result_next.nack_seen = st_next.nack;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= StReset;
            result_reg <= '0;
        end else if (step_en) begin
            st_reg     <= st_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: src/i2c_master_register_access_core.sv
// The result for an accepted item is registered and appears on the m_ side
// at the clock edge that accepts it.
// Throughput: one item per cycle; the result register frees whenever m_ready is
// high, so s_ready follows m_ready while a result is held.
// Reset (aresetn low, synchronous): sequencer idle with SCL and SDA high, result
// outputs zero (m_scl low), no result pending, half_bit_ticks back to 50.
module i2c_master_register_access_core import i2cra_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_valid,
    input  logic        s_req_type,
    input  logic [6:0]  s_dev_addr,
    input  logic [7:0]  s_reg_addr,
    input  logic [7:0]  s_wr_data,
    input  logic [7:0]  s_byte_count,
    input  logic        s_sda_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl,
    output logic        m_sda_out,
    output logic        m_sda_oe,
    output logic        m_busy_res,
    output logic        m_rd_valid,
    output logic [7:0]  m_rd_data,
    output logic        m_rd_last,
    output logic        m_nack_seen
);

    logic [TicksW-1:0] ticks_reg;
    logic              m_valid_reg;
    logic              step_en;
    item_t             item;
    result_t           result;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign step_en   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg   <= TicksReset;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                ticks_reg <= cfg_data;
            end
            if (step_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign item.req_valid  = s_req_valid;
    assign item.req_type   = s_req_type;
    assign item.dev_addr   = s_dev_addr;
    assign item.reg_addr   = s_reg_addr;
    assign item.wr_data    = s_wr_data;
    assign item.byte_count = s_byte_count;
    assign item.sda_in     = s_sda_in;

    i2cra_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step_en),
        .item           (item),
        .half_bit_ticks (ticks_reg),
        .result         (result)
    );

    assign m_valid     = m_valid_reg;
    assign m_scl       = result.scl;
    assign m_sda_out   = result.sda_out;
    assign m_sda_oe    = result.sda_oe;
    assign m_busy_res  = result.busy_res;
    assign m_rd_valid  = result.rd_valid;
    assign m_rd_data   = result.rd_data;
    assign m_rd_last   = result.rd_last;
    assign m_nack_seen = result.nack_seen;

endmodule

// File: src/i2cra_checker.sv
module i2cra_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl,
    input logic       m_sda_out,
    input logic       m_sda_oe,
    input logic       m_busy_res,
    input logic       m_rd_valid,
    input logic [7:0] m_rd_data,
    input logic       m_rd_last
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scl) && $stable(m_rd_data))
        else $error("result changed while stalled");

    // the input side only stalls behind a held result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sda_oe |-> !m_sda_out)
        else $error("SDA level shown while released");

    a_rd_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rd_valid |-> m_busy_res && m_sda_oe)
        else $error("read byte outside a transaction");

    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rd_valid |-> m_rd_data == 8'd0 && !m_rd_last)
        else $error("read fields set without a byte");

endmodule

bind i2c_master_register_access_core i2cra_checker u_i2cra_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_scl      (m_scl),
    .m_sda_out  (m_sda_out),
    .m_sda_oe   (m_sda_oe),
    .m_busy_res (m_busy_res),
    .m_rd_valid (m_rd_valid),
    .m_rd_data  (m_rd_data),
    .m_rd_last  (m_rd_last)
);
